[rtl/dutc_pkg.sv]
// Shared widths, status codes, reciprocal constants and calendar tables of the converter.
package dutc_pkg;

	localparam int STAMP_W  = 32;
	localparam int SECS_W   = 33;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_MONTH_ZERO = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_YEAR_RANGE = 2'd2;

	// floor(2^36 / 675), floor estimate, corrected by one compare
	localparam logic [26:0] RECIP_675  = 27'd101806632;
	// ceil(2^23 / 60), exact below 2^17
	localparam logic [17:0] RECIP_60   = 18'd139811;
	// ceil(2^29 / 1460), exact below 2^18
	localparam logic [18:0] RECIP_1460 = 19'd367720;
	// ceil(2^27 / 365), exact below 2^18
	localparam logic [18:0] RECIP_365  = 19'd367720;
	// ceil(2^20 / 153), exact below 2^11
	localparam logic [12:0] RECIP_153  = 13'd6854;

	typedef struct packed {
		logic              zero;
		logic              mon_zero;
		logic [SECS_W-1:0] secs;
	} dos_res_t;

	function automatic logic [8:0] month_start_days(input logic [3:0] idx);
		logic [8:0] r;
		unique case (idx)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd59;
			4'd3:    r = 9'd90;
			4'd4:    r = 9'd120;
			4'd5:    r = 9'd151;
			4'd6:    r = 9'd181;
			4'd7:    r = 9'd212;
			4'd8:    r = 9'd243;
			4'd9:    r = 9'd273;
			4'd10:   r = 9'd304;
			4'd11:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// first day of each month in a March-based year
	function automatic logic [8:0] civil_month_offset(input logic [3:0] mp);
		logic [8:0] r;
		unique case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

[rtl/dutc_if.sv]
// Valid/ready channel interfaces for request and result words of the converter.
interface dutc_in_if;
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [dutc_pkg::STAMP_W-1:0] dos_stamp;
	logic [dutc_pkg::SECS_W-1:0]  unix_seconds;

	modport source (output valid, output kind, output dos_stamp, output unix_seconds,
		input ready);
	modport sink (input valid, input kind, input dos_stamp, input unix_seconds,
		output ready);
endinterface

interface dutc_out_if;
	logic                          valid;
	logic                          ready;
	logic [dutc_pkg::SECS_W-1:0]   seconds_out;
	logic [dutc_pkg::STAMP_W-1:0]  stamp_out;
	logic [dutc_pkg::STATUS_W-1:0] status;

	modport source (output valid, output seconds_out, output stamp_out, output status,
		input ready);
	modport sink (input valid, input seconds_out, input stamp_out, input status,
		output ready);
endinterface

[rtl/dos_unix_timestamp_converter_core.sv]
// Top level: eleven-stage pipelined DOS/Unix timestamp converter.
// Throughput: one word per cycle while res.ready is high; stages advance independently, so bubbles close up.
// Divisions by constants run as reciprocal multiplies, at most one per stage and lane; century terms use compares.
// Reset clears the stage valid bits only; payload registers are not reset.
module dos_unix_timestamp_converter_core (
	input  logic       clk,
	input  logic       arst_n,
	dutc_in_if.sink    cmd,
	dutc_out_if.source res
);

	localparam int NS = 11;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} tod_t;

	logic [NS-1:0] valid_q;
	logic [NS-1:0] full;
	logic [NS-1:0] en;

	always_comb begin
		full[NS-1] = valid_q[NS-1];
		for (int k = NS - 2; k >= 0; k--) begin
			full[k] = valid_q[k] & full[k+1];
		end
		en = {NS{res.ready}} | ~full;
	end

	assign cmd.ready = en[0];
	assign res.valid = valid_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0]) begin
				valid_q[0] <= cmd.valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	// stage 1: unpack DOS fields, start the divide by 86400
	logic [3:0]  monf;
	logic        roll;
	logic [52:0] up_c;

	assign monf = cmd.dos_stamp[24:21];
	assign roll = monf >= 4'd13;
	assign up_c = {27'd0, cmd.unix_seconds[32:7]} * {26'd0, dutc_pkg::RECIP_675};

	logic        kind_s1, dz_s1, monz_s1, uz_s1;
	logic [7:0]  yo_s1;
	logic [3:0]  midx_s1;
	logic [4:0]  mday_s1, hour_s1, sec2_s1;
	logic [5:0]  minute_s1;
	logic [25:0] ux_s1;
	logic [6:0]  ulo_s1;
	logic [52:0] up_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			kind_s1   <= cmd.kind;
			dz_s1     <= cmd.dos_stamp == '0;
			monz_s1   <= monf == 4'd0;
			yo_s1     <= {1'b0, cmd.dos_stamp[31:25]} + {7'd0, roll};
			midx_s1   <= roll ? monf - 4'd13 : monf - 4'd1;
			mday_s1   <= cmd.dos_stamp[20:16];
			hour_s1   <= cmd.dos_stamp[15:11];
			minute_s1 <= cmd.dos_stamp[10:5];
			sec2_s1   <= cmd.dos_stamp[4:0];
			uz_s1     <= cmd.unix_seconds == '0;
			ux_s1     <= cmd.unix_seconds[32:7];
			ulo_s1    <= cmd.unix_seconds[6:0];
			up_s1     <= up_c;
		end
	end

	// stage 2: DOS day count and time of day; first remainder of seconds / 86400
	logic        leapadj, over2100;
	logic [16:0] days_c, tod_c, q0_c;
	logic [25:0] r0_c;

	assign over2100 = yo_s1 >= 8'd120;
	assign leapadj  = (yo_s1[1:0] == 2'd0) && (yo_s1 != 8'd120) && (midx_s1 < 4'd2);
	assign days_c   = ({9'd0, yo_s1} + 17'd10) * 17'd365
		+ {8'd0, dutc_pkg::month_start_days(midx_s1)}
		+ {9'd0, (yo_s1 + 8'd12) >> 2}
		+ {12'd0, mday_s1} - 17'd1 - {16'd0, leapadj} - {16'd0, over2100};
	assign tod_c    = {12'd0, hour_s1} * 17'd3600 + {11'd0, minute_s1} * 17'd60
		+ {11'd0, sec2_s1, 1'b0};
	assign q0_c     = up_s1[52:36];
	assign r0_c     = ux_s1 - {9'd0, q0_c} * 26'd675;

	logic        kind_s2, dz_s2, monz_s2, uz_s2;
	logic [16:0] days_s2, tod_s2, q0_s2;
	logic [10:0] r0_s2;
	logic [6:0]  ulo_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			kind_s2 <= kind_s1;
			dz_s2   <= dz_s1;
			monz_s2 <= monz_s1;
			uz_s2   <= uz_s1;
			days_s2 <= days_c;
			tod_s2  <= tod_c;
			q0_s2   <= q0_c;
			r0_s2   <= r0_c[10:0];
			ulo_s2  <= ulo_s1;
		end
	end

	// stage 3: DOS total seconds; correct the day quotient
	logic [33:0] total_c;
	logic        corr;
	logic [10:0] r_c;

	assign total_c = {17'd0, days_s2} * 34'd86400 + {17'd0, tod_s2};
	assign corr    = r0_s2 >= 11'd675;
	assign r_c     = corr ? r0_s2 - 11'd675 : r0_s2;

	logic                kind_s3, uz_s3;
	dutc_pkg::dos_res_t  dres_s3;
	logic [16:0]         udays_s3, rem_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			kind_s3  <= kind_s2;
			uz_s3    <= uz_s2;
			dres_s3  <= '{zero: dz_s2, mon_zero: monz_s2, secs: total_c[32:0]};
			udays_s3 <= q0_s2 + {16'd0, corr};
			rem_s3   <= {r_c[9:0], ulo_s2};
		end
	end

	// stage 4: minutes of day; era and day of era
	logic [34:0] pm_c;
	logic        era5_c;

	assign pm_c   = {17'd0, rem_s3} * {17'd0, dutc_pkg::RECIP_60};
	assign era5_c = udays_s3 >= 17'd11017;

	logic               kind_s4, uz_s4, era5_s4;
	dutc_pkg::dos_res_t dres_s4;
	logic [16:0]        rem_s4;
	logic [10:0]        mt_s4;
	logic [17:0]        doe_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			kind_s4 <= kind_s3;
			uz_s4   <= uz_s3;
			dres_s4 <= dres_s3;
			rem_s4  <= rem_s3;
			mt_s4   <= pm_c[33:23];
			era5_s4 <= era5_c;
			doe_s4  <= era5_c ? {1'b0, udays_s3} - 18'd11017 : {1'b0, udays_s3} + 18'd135080;
		end
	end

	// stage 5: hour and second; leap-day terms of the day of era
	logic [16:0] sdiff_c;
	logic [28:0] ph_c;
	logic [36:0] pa_c;
	logic [2:0]  b_c;

	assign sdiff_c = rem_s4 - {6'd0, mt_s4} * 17'd60;
	assign ph_c    = {18'd0, mt_s4} * {11'd0, dutc_pkg::RECIP_60};
	assign pa_c    = {19'd0, doe_s4} * {18'd0, dutc_pkg::RECIP_1460};
	assign b_c     = {2'd0, doe_s4 >= 18'd36524} + {2'd0, doe_s4 >= 18'd73048}
		+ {2'd0, doe_s4 >= 18'd109572} + {2'd0, doe_s4 >= 18'd146096};

	logic               kind_s5, uz_s5, era5_s5, c_s5;
	dutc_pkg::dos_res_t dres_s5;
	logic [10:0]        mt_s5;
	logic [4:0]         hr_s5;
	logic [5:0]         sec_s5;
	logic [17:0]        doe_s5;
	logic [6:0]         a_s5;
	logic [2:0]         b_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			kind_s5 <= kind_s4;
			uz_s5   <= uz_s4;
			dres_s5 <= dres_s4;
			era5_s5 <= era5_s4;
			mt_s5   <= mt_s4;
			hr_s5   <= ph_c[27:23];
			sec_s5  <= sdiff_c[5:0];
			doe_s5  <= doe_s4;
			a_s5    <= pa_c[35:29];
			b_s5    <= b_c;
			c_s5    <= doe_s4 == 18'd146096;
		end
	end

	// stage 6: minute; adjusted day of era
	logic [10:0] mdiff_c;

	assign mdiff_c = mt_s5 - {6'd0, hr_s5} * 11'd60;

	logic               kind_s6, uz_s6, era5_s6;
	dutc_pkg::dos_res_t dres_s6;
	logic [17:0]        doe_s6, t_s6;
	tod_t               tod_s6;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			kind_s6 <= kind_s5;
			uz_s6   <= uz_s5;
			dres_s6 <= dres_s5;
			era5_s6 <= era5_s5;
			doe_s6  <= doe_s5;
			t_s6    <= doe_s5 - {11'd0, a_s5} + {15'd0, b_s5} - {17'd0, c_s5};
			tod_s6  <= '{hour: hr_s5, minute: mdiff_c[5:0], second: sec_s5};
		end
	end

	// stage 7: year of era
	logic [36:0] py_c;

	assign py_c = {19'd0, t_s6} * {18'd0, dutc_pkg::RECIP_365};

	logic               kind_s7, uz_s7, era5_s7;
	dutc_pkg::dos_res_t dres_s7;
	logic [17:0]        doe_s7;
	logic [8:0]         yoe_s7;
	tod_t               tod_s7;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			kind_s7 <= kind_s6;
			uz_s7   <= uz_s6;
			dres_s7 <= dres_s6;
			era5_s7 <= era5_s6;
			doe_s7  <= doe_s6;
			yoe_s7  <= py_c[35:27];
			tod_s7  <= tod_s6;
		end
	end

	// stage 8: day of year and March-based year
	logic [1:0]  cent_c;
	logic [17:0] sub_c, doy_c;

	assign cent_c = {1'b0, yoe_s7 >= 9'd100} + {1'b0, yoe_s7 >= 9'd200}
		+ {1'b0, yoe_s7 >= 9'd300};
	assign sub_c  = {9'd0, yoe_s7} * 18'd365 + {11'd0, yoe_s7[8:2]} - {16'd0, cent_c};
	assign doy_c  = doe_s7 - sub_c;

	logic               kind_s8, uz_s8;
	dutc_pkg::dos_res_t dres_s8;
	logic [8:0]         doy_s8;
	logic [11:0]        y0_s8;
	tod_t               tod_s8;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			kind_s8 <= kind_s7;
			uz_s8   <= uz_s7;
			dres_s8 <= dres_s7;
			doy_s8  <= doy_c[8:0];
			y0_s8   <= {3'd0, yoe_s7} + (era5_s7 ? 12'd2000 : 12'd1600);
			tod_s8  <= tod_s7;
		end
	end

	// stage 9: March-based month
	logic [10:0] x5_c;
	logic [23:0] pmp_c;

	assign x5_c  = {2'd0, doy_s8} * 11'd5 + 11'd2;
	assign pmp_c = {13'd0, x5_c} * {11'd0, dutc_pkg::RECIP_153};

	logic               kind_s9, uz_s9;
	dutc_pkg::dos_res_t dres_s9;
	logic [8:0]         doy_s9;
	logic [11:0]        y0_s9;
	logic [3:0]         mp_s9;
	tod_t               tod_s9;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			kind_s9 <= kind_s8;
			uz_s9   <= uz_s8;
			dres_s9 <= dres_s8;
			doy_s9  <= doy_s8;
			y0_s9   <= y0_s8;
			mp_s9   <= pmp_c[23:20];
			tod_s9  <= tod_s8;
		end
	end

	// stage 10: day, month and year
	logic [8:0] dd_c;
	logic       late_c;

	assign dd_c   = doy_s9 - dutc_pkg::civil_month_offset(mp_s9) + 9'd1;
	assign late_c = mp_s9 >= 4'd10;

	logic               kind_s10, uz_s10;
	dutc_pkg::dos_res_t dres_s10;
	logic [4:0]         day_s10;
	logic [3:0]         mon_s10;
	logic [11:0]        year_s10;
	tod_t               tod_s10;

	always_ff @(posedge clk) begin
		if (en[9]) begin
			kind_s10 <= kind_s9;
			uz_s10   <= uz_s9;
			dres_s10 <= dres_s9;
			day_s10  <= dd_c[4:0];
			mon_s10  <= late_c ? mp_s9 - 4'd9 : mp_s9 + 4'd3;
			year_s10 <= y0_s9 + {11'd0, late_c};
			tod_s10  <= tod_s9;
		end
	end

	// stage 11: range check, pack and select the direction
	logic        bad_c;
	logic [11:0] yo_c;

	assign bad_c = (year_s10 < 12'd1980) || (year_s10 > 12'd2107);
	assign yo_c  = year_s10 - 12'd1980;

	logic [dutc_pkg::SECS_W-1:0]   secs_s11;
	logic [dutc_pkg::STAMP_W-1:0]  stamp_s11;
	logic [dutc_pkg::STATUS_W-1:0] status_s11;

	always_ff @(posedge clk) begin
		if (en[10]) begin
			if (kind_s10) begin
				secs_s11 <= '0;
				if (uz_s10) begin
					stamp_s11  <= '0;
					status_s11 <= dutc_pkg::STATUS_OK;
				end else if (bad_c) begin
					stamp_s11  <= '0;
					status_s11 <= dutc_pkg::STATUS_YEAR_RANGE;
				end else begin
					stamp_s11  <= {yo_c[6:0], mon_s10, day_s10, tod_s10.hour,
						tod_s10.minute, tod_s10.second[5:1]};
					status_s11 <= dutc_pkg::STATUS_OK;
				end
			end else begin
				stamp_s11 <= '0;
				if (dres_s10.zero) begin
					secs_s11   <= '0;
					status_s11 <= dutc_pkg::STATUS_OK;
				end else if (dres_s10.mon_zero) begin
					secs_s11   <= '0;
					status_s11 <= dutc_pkg::STATUS_MONTH_ZERO;
				end else begin
					secs_s11   <= dres_s10.secs;
					status_s11 <= dutc_pkg::STATUS_OK;
				end
			end
		end
	end

	assign res.seconds_out = secs_s11;
	assign res.stamp_out   = stamp_s11;
	assign res.status      = status_s11;

endmodule

[tb/tb_dos_unix_timestamp_converter_core.sv]
// Self-checking testbench for the DOS/Unix timestamp converter core.
module tb_dos_unix_timestamp_converter_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam bit KIND_DOS2UNIX = 1'b0;
	localparam bit KIND_UNIX2DOS = 1'b1;

	localparam int NUM_DIRECTED = 20;
	localparam int NUM_RANDOM   = 1200;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 300;
	localparam int PAUSE_AT     = 800;
	localparam int DRAIN_CYCLES = 30;
	localparam int IDLE_LIMIT   = 4000;
	localparam int MAX_REPORTS  = 10;

	localparam longint UNIX_1980 = 64'd315532800;
	localparam longint UNIX_2108 = 64'd4354819200;
	localparam longint UNIX_2_32 = 64'd4294967296;

	localparam int DAYS_BEFORE_MONTH [12] = '{
		0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
	};

	typedef struct packed {
		logic [dutc_pkg::SECS_W-1:0]   secs;
		logic [dutc_pkg::STAMP_W-1:0]  stamp;
		logic [dutc_pkg::STATUS_W-1:0] status;
	} conv_res_t;

	typedef struct packed {
		bit                          kind;
		bit [dutc_pkg::STAMP_W-1:0]  dos;
		bit [dutc_pkg::SECS_W-1:0]   unx;
		bit                          known;
		conv_res_t                   want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dutc_in_if  cmd_if ();
	dutc_out_if res_if ();

	dos_unix_timestamp_converter_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.res    (res_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// leading rows carry their result inline, the rest go through convert_stamp
	dir_row_t dir_rows [NUM_DIRECTED] = '{
		'{KIND_DOS2UNIX, 32'h0000_0000, 33'h1_2345_6789, 1'b1,
			'{33'd0, 32'd0, dutc_pkg::STATUS_OK}},
		'{KIND_UNIX2DOS, 32'hDEAD_BEEF, 33'd0, 1'b1, '{33'd0, 32'd0, dutc_pkg::STATUS_OK}},
		'{KIND_DOS2UNIX, 32'h0021_0000, 33'h1_FFFF_FFFF, 1'b1,
			'{33'd315532800, 32'd0, dutc_pkg::STATUS_OK}},
		'{KIND_UNIX2DOS, 32'h0000_0000, 33'd315532800, 1'b1,
			'{33'd0, 32'h0021_0000, dutc_pkg::STATUS_OK}},
		'{KIND_DOS2UNIX, 32'h0001_0000, 33'd0, 1'b1,
			'{33'd0, 32'd0, dutc_pkg::STATUS_MONTH_ZERO}},
		'{KIND_DOS2UNIX, 32'hFE1F_FFFF, 33'd0, 1'b1,
			'{33'd0, 32'd0, dutc_pkg::STATUS_MONTH_ZERO}},
		'{KIND_UNIX2DOS, 32'h0000_0000, 33'd1, 1'b1,
			'{33'd0, 32'd0, dutc_pkg::STATUS_YEAR_RANGE}},
		'{KIND_UNIX2DOS, 32'hFFFF_FFFF, 33'd315532799, 1'b1,
			'{33'd0, 32'd0, dutc_pkg::STATUS_YEAR_RANGE}},
		'{KIND_UNIX2DOS, 32'h0000_0000, 33'h1_FFFF_FFFF, 1'b1,
			'{33'd0, 32'd0, dutc_pkg::STATUS_YEAR_RANGE}},
		'{KIND_UNIX2DOS, 32'h0000_0000, 33'd4354819200, 1'b1,
			'{33'd0, 32'd0, dutc_pkg::STATUS_YEAR_RANGE}},
		'{KIND_DOS2UNIX, 32'hFFFF_FFFF, 33'd0, 1'b0, '0},
		'{KIND_DOS2UNIX, 32'hFFA1_0000, 33'd0, 1'b0, '0},
		'{KIND_DOS2UNIX, 32'h27DD_0000, 33'd0, 1'b0, '0},
		'{KIND_DOS2UNIX, 32'h2860_0000, 33'd0, 1'b0, '0},
		'{KIND_DOS2UNIX, 32'h0021_FFFF, 33'd0, 1'b0, '0},
		'{KIND_DOS2UNIX, 32'hF061_0000, 33'd0, 1'b0, '0},
		'{KIND_UNIX2DOS, 32'h0000_0000, 33'd4354819199, 1'b0, '0},
		'{KIND_UNIX2DOS, 32'h1234_5678, 33'd315532801, 1'b0, '0},
		'{KIND_UNIX2DOS, 32'h0000_0000, 33'd951827697, 1'b0, '0},
		'{KIND_UNIX2DOS, 32'hFFFF_FFFF, 33'h1_0000_0000, 1'b0, '0}
	};

	conv_res_t awaited_conversions [$];
	int        errors = 0;
	int        words_accepted = 0;
	int        results_seen = 0;
	int        dos_results = 0;
	int        unix_results = 0;
	int        month_zero_seen = 0;
	int        year_range_seen = 0;
	int        idle_cycles = 0;
	bit        hold_done = 1'b0;

	function automatic conv_res_t convert_stamp(input bit kind,
		input bit [dutc_pkg::STAMP_W-1:0] dos, input bit [dutc_pkg::SECS_W-1:0] unx);
		conv_res_t r;
		longint year, midx, days, total;
		longint unsigned s, dn, rem, z, era, doe, yoe, y, doy, mp, d, m, hr, mi, sc, yoff;
		r = '0;
		r.status = dutc_pkg::STATUS_OK;
		if (kind == KIND_DOS2UNIX) begin
			if (dos != '0) begin
				if (dos[24:21] == 4'd0) begin
					r.status = dutc_pkg::STATUS_MONTH_ZERO;
				end else begin
					year = 1980 + longint'(dos[31:25]);
					midx = longint'(dos[24:21]) - 1;
					if (midx >= 12) begin
						year += 1;
						midx -= 12;
					end
					days = (year - 1970) * 365 + DAYS_BEFORE_MONTH[midx] + (year - 1968) / 4
						- (year - 1900) / 100 + (year - 1600) / 400;
					if (year % 4 == 0 && (year % 100 != 0 || year % 400 == 0) && midx < 2)
						days -= 1;
					days += longint'(dos[20:16]) - 1;
					total = (days * 24 + longint'(dos[15:11])) * 60 + longint'(dos[10:5]);
					total = total * 60 + 2 * longint'(dos[4:0]);
					r.secs = total[dutc_pkg::SECS_W-1:0];
				end
			end
		end else if (unx != '0) begin
			s = 64'(unx);
			dn = s / 86400;
			rem = s % 86400;
			hr = rem / 3600;
			mi = (rem % 3600) / 60;
			sc = rem % 60;
			z = dn + 719468;
			era = z / 146097;
			doe = z - era * 146097;
			yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
			y = yoe + era * 400;
			doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
			mp = (5 * doy + 2) / 153;
			d = doy - (153 * mp + 2) / 5 + 1;
			m = (mp < 10) ? mp + 3 : mp - 9;
			if (m <= 2)
				y += 1;
			if (y < 1980 || y > 2107) begin
				r.status = dutc_pkg::STATUS_YEAR_RANGE;
			end else begin
				yoff = y - 1980;
				r.stamp = {yoff[6:0], m[3:0], d[4:0], hr[4:0], mi[5:0], sc[5:1]};
			end
		end
		return r;
	endfunction

	task automatic offer_word(input bit kind, input bit [dutc_pkg::STAMP_W-1:0] dos,
		input bit [dutc_pkg::SECS_W-1:0] unx, input conv_res_t want, input int gap,
		input bit drain_first);
		if (gap > 0 || drain_first) begin
			cmd_if.valid <= 1'b0;
			if (drain_first)
				do @(posedge clk); while (awaited_conversions.size() != 0);
			repeat (gap) @(posedge clk);
		end
		cmd_if.valid        <= 1'b1;
		cmd_if.kind         <= kind;
		cmd_if.dos_stamp    <= dos;
		cmd_if.unix_seconds <= unx;
		@(posedge clk);
		while (!cmd_if.ready) @(posedge clk);
		awaited_conversions.push_back(want);
		words_accepted++;
	endtask

	task automatic check_result();
		conv_res_t want;
		results_seen++;
		if (awaited_conversions.size() == 0) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: unexpected result word seconds_out=%0d stamp_out=%h status=%0d",
					$realtime, res_if.seconds_out, res_if.stamp_out, res_if.status);
		end else begin
			want = awaited_conversions.pop_front();
			if (res_if.seconds_out !== want.secs || res_if.stamp_out !== want.stamp ||
				res_if.status !== want.status) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("%0t: result %0d mismatch: seconds_out exp %0d got %0d",
						$realtime, results_seen, want.secs, res_if.seconds_out);
					$display("    stamp_out exp %h got %h, status exp %0d got %0d",
						want.stamp, res_if.stamp_out, want.status, res_if.status);
				end
			end
			if (want.stamp != '0)
				unix_results++;
			else if (want.secs != '0)
				dos_results++;
			if (res_if.status == dutc_pkg::STATUS_MONTH_ZERO)
				month_zero_seen++;
			if (res_if.status == dutc_pkg::STATUS_YEAR_RANGE)
				year_range_seen++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
				$display("dos_unix_timestamp_converter_core regression: fail");
				$finish;
			end
		end
	end

	initial begin
		int  stall;
		bit  burst;
		res_if.ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!hold_done && words_accepted >= HOLD_AT) begin
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			burst = ((results_seen / 80) % 4 == 2);
			stall = burst ? 0 : $urandom_range(16, 0);
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			@(posedge clk);
			while (!res_if.valid) @(posedge clk);
			check_result();
		end
	end

	initial begin
		dir_row_t                    row;
		conv_res_t                   want;
		bit                          kind;
		bit [dutc_pkg::STAMP_W-1:0]  dos;
		bit [dutc_pkg::SECS_W-1:0]   unx;
		longint                      near;
		int                          gap;
		int                          pick;
		cmd_if.valid        = 1'b0;
		cmd_if.kind         = KIND_DOS2UNIX;
		cmd_if.dos_stamp    = '0;
		cmd_if.unix_seconds = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			row = dir_rows[i];
			want = row.known ? row.want : convert_stamp(row.kind, row.dos, row.unx);
			offer_word(row.kind, row.dos, row.unx, want, $urandom_range(16, 0), 1'b0);
		end

		for (int i = 0; i < NUM_RANDOM; i++) begin
			dos = $urandom();
			unx = {1'($urandom_range(1, 0)), $urandom()};
			kind = KIND_DOS2UNIX;
			pick = $urandom_range(9, 0);
			if (pick <= 3) begin
				dos = {7'($urandom_range(127, 0)),
					4'(($urandom_range(3, 0) == 0) ? $urandom_range(15, 13)
						: $urandom_range(12, 1)),
					5'($urandom_range(31, 1)), 5'($urandom_range(23, 0)),
					6'($urandom_range(59, 0)), 5'($urandom_range(29, 0))};
			end else if (pick <= 7 && pick >= 5) begin
				kind = KIND_UNIX2DOS;
				unx = 33'(UNIX_1980 + longint'($urandom_range(32'd4039286399, 0)));
			end else if (pick == 8) begin
				kind = KIND_UNIX2DOS;
			end else if (pick == 9) begin
				near = longint'($urandom_range(400000, 0)) - 200000;
				case ($urandom_range(3, 0))
					0: begin
						kind = KIND_UNIX2DOS;
						unx = 33'(UNIX_1980 + near);
					end
					1: begin
						kind = KIND_UNIX2DOS;
						unx = 33'(UNIX_2108 + near);
					end
					2: begin
						kind = KIND_UNIX2DOS;
						unx = 33'(UNIX_2_32 + near);
					end
					default: begin
						dos = {7'($urandom_range(127, 0)), 4'($urandom_range(15, 13)), 5'd0,
							5'($urandom_range(31, 24)), 6'($urandom_range(63, 60)),
							5'($urandom_range(31, 30))};
					end
				endcase
			end
			// keep offering while the result side is held off
			if (!hold_done && words_accepted >= HOLD_AT)
				gap = 0;
			else
				gap = ((i / 64) % 4 == 0) ? 0 : $urandom_range(16, 0);
			offer_word(kind, dos, unx, convert_stamp(kind, dos, unx), gap, i == PAUSE_AT);
		end

		cmd_if.valid <= 1'b0;
		while (awaited_conversions.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d directed and %0d random words, %0d DOS-to-Unix, %0d Unix-to-DOS",
			NUM_DIRECTED, NUM_RANDOM, dos_results, unix_results);
		$display("status codes seen: %0d month zero, %0d year range; %0d mismatches",
			month_zero_seen, year_range_seen, errors);
		if (errors == 0)
			$display("dos_unix_timestamp_converter_core regression: pass");
		else
			$display("dos_unix_timestamp_converter_core regression: fail");
		$finish;
	end

endmodule
